// ===== sv/tsq_pkg.sv =====
// Shared constants, types and a helper function of the transform-to-scale-quaternion unit.
`default_nettype none

package tsq_pkg;

    localparam int DATA_W           = 32;
    localparam int SQ_W             = 64;
    localparam int QUO_W            = 32;
    localparam int DEN_W            = 33;
    localparam int MATRIX_FRAC_BITS = 16;

    localparam logic signed [34:0] ARG_ONE = 35'sh0_4000_0000;
    localparam logic        [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic        [31:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic        [31:0] Q_MIN   = 32'h8000_0000;

    // Which diagonal term leads the quaternion extraction.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Applies sign and saturation to an unsigned quotient magnitude.
    function automatic logic [31:0] sat_q30(input logic [31:0] q, input logic ovf,
                                            input logic neg);
        logic [31:0] res;
        if (ovf) begin
            res = neg ? Q_MIN : Q_MAX;
        end else if (neg) begin
            res = q[31] ? Q_MIN : (32'd0 - q);
        end else begin
            res = q[31] ? Q_MAX : q;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tsq_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per register stage, over LANES parallel lanes.
`default_nettype none

module tsq_sqrt_pipe
    import tsq_pkg::*;
#(
    parameter int LANES = 1,
    parameter int W     = SQ_W,
    parameter int PW    = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][W-1:0]       in_x,
    input  wire logic [PW-1:0]                 in_pay,
    output logic                               out_valid,
    output logic      [LANES-1:0][W/2-1:0]     out_root,
    output logic      [PW-1:0]                 out_pay
);

    localparam int N  = W / 2;
    localparam int RW = N + 2;

    logic [LANES-1:0][W-1:0]  x_reg    [1:N-1];
    logic [LANES-1:0][RW-1:0] rem_reg  [1:N-1];
    logic [LANES-1:0][N-1:0]  root_reg [1:N];
    logic [PW-1:0]            pay_reg  [1:N];
    logic [N:1]               valid_reg;

    logic [LANES-1:0][W-1:0]  x_src    [0:N-1];
    logic [LANES-1:0][RW-1:0] rem_src  [0:N-1];
    logic [LANES-1:0][N-1:0]  root_src [0:N-1];
    logic [LANES-1:0][W-1:0]  x_next    [1:N-1];
    logic [LANES-1:0][RW-1:0] rem_next  [1:N-1];
    logic [LANES-1:0][N-1:0]  root_next [1:N];

    logic [RW-1:0] rs;
    logic [RW-1:0] tr;
    logic          ge;

    always_comb begin
        x_src[0]    = in_x;
        rem_src[0]  = '0;
        root_src[0] = '0;
        for (int k = 1; k < N; k++) begin
            x_src[k]    = x_reg[k];
            rem_src[k]  = rem_reg[k];
            root_src[k] = root_reg[k];
        end
        for (int k = 0; k < N; k++) begin
            for (int l = 0; l < LANES; l++) begin
                rs = {rem_src[k][l][RW-3:0], x_src[k][l][W-1-2*k -: 2]};
                tr = {root_src[k][l], 2'b01};
                ge = (rs >= tr);
                root_next[k+1][l] = {root_src[k][l][N-2:0], ge};
                if (k < N - 1) begin
                    rem_next[k+1][l] = ge ? (rs - tr) : rs;
                    x_next[k+1][l]   = x_src[k][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-1:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[1] <= in_pay;
            for (int k = 2; k <= N; k++) begin
                pay_reg[k] <= pay_reg[k-1];
            end
            for (int k = 1; k <= N; k++) begin
                root_reg[k] <= root_next[k];
            end
            for (int k = 1; k < N; k++) begin
                rem_reg[k] <= rem_next[k];
                x_reg[k]   <= x_next[k];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_root  = root_reg[N];
    assign out_pay   = pay_reg[N];

endmodule

`default_nettype wire

// ===== sv/tsq_div_pipe.sv =====
// Pipelined Q30 divider, one quotient bit per register stage, with overflow detection.
`default_nettype none

module tsq_div_pipe
    import tsq_pkg::*;
#(
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][DATA_W-1:0]  in_mag,
    input  wire logic [LANES-1:0]              in_neg,
    input  wire logic [LANES-1:0][DEN_W-1:0]   in_den,
    input  wire logic [PW-1:0]                 in_pay,
    output logic                               out_valid,
    output logic      [LANES-1:0][QUO_W-1:0]   out_q,
    output logic      [LANES-1:0]              out_ovf,
    output logic      [LANES-1:0]              out_neg,
    output logic      [PW-1:0]                 out_pay
);

    localparam int N  = QUO_W;
    localparam int RW = DEN_W + 1;

    logic [LANES-1:0][DATA_W-1:0] mag_reg [1:N-1];
    logic [LANES-1:0][DEN_W-1:0]  den_reg [1:N-1];
    logic [LANES-1:0][RW-1:0]     rem_reg [1:N-1];
    logic [LANES-1:0][N-1:0]      q_reg   [1:N];
    logic [LANES-1:0]             ovf_reg [1:N];
    logic [LANES-1:0]             neg_reg [1:N];
    logic [PW-1:0]                pay_reg [1:N];
    logic [N:1]                   valid_reg;

    logic [LANES-1:0][DATA_W-1:0] mag_src [0:N-1];
    logic [LANES-1:0][DEN_W-1:0]  den_src [0:N-1];
    logic [LANES-1:0][RW-1:0]     rem_src [0:N-1];
    logic [LANES-1:0][N-1:0]      q_src   [0:N-1];
    logic [LANES-1:0][RW-1:0]     rem_next [1:N-1];
    logic [LANES-1:0][N-1:0]      q_next   [1:N];
    logic [LANES-1:0]             ovf_in;

    logic [RW-1:0] rs;
    logic          b;
    logic          ge;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            // The quotient needs more than 32 bits exactly when mag >= 4 * den.
            ovf_in[l]     = ({3'b000, in_mag[l]} >= {in_den[l], 2'b00});
            rem_src[0][l] = RW'(in_mag[l][DATA_W-1:2]);
        end
        mag_src[0] = in_mag;
        den_src[0] = in_den;
        q_src[0]   = '0;
        for (int k = 1; k < N; k++) begin
            mag_src[k] = mag_reg[k];
            den_src[k] = den_reg[k];
            rem_src[k] = rem_reg[k];
            q_src[k]   = q_reg[k];
        end
        for (int k = 0; k < N; k++) begin
            for (int l = 0; l < LANES; l++) begin
                // Only the top two dividend bits below the initial remainder can be nonzero.
                if (k == 0) begin
                    b = mag_src[k][l][1];
                end else if (k == 1) begin
                    b = mag_src[k][l][0];
                end else begin
                    b = 1'b0;
                end
                rs = {rem_src[k][l][RW-2:0], b};
                ge = (rs >= RW'(den_src[k][l]));
                q_next[k+1][l] = {q_src[k][l][N-2:0], ge};
                if (k < N - 1) begin
                    rem_next[k+1][l] = ge ? (rs - RW'(den_src[k][l])) : rs;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-1:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[1] <= in_pay;
            ovf_reg[1] <= ovf_in;
            neg_reg[1] <= in_neg;
            for (int k = 2; k <= N; k++) begin
                pay_reg[k] <= pay_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int k = 1; k <= N; k++) begin
                q_reg[k] <= q_next[k];
            end
            for (int k = 1; k < N; k++) begin
                rem_reg[k] <= rem_next[k];
                mag_reg[k] <= mag_src[k-1];
                den_reg[k] <= den_src[k-1];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_q     = q_reg[N];
    assign out_ovf   = ovf_reg[N];
    assign out_neg   = neg_reg[N];
    assign out_pay   = pay_reg[N];

endmodule

`default_nettype wire

// ===== sv/transform_to_scale_quaternion_unit.sv =====
// Top level of the transform-to-scale-quaternion unit.
// The unit takes one 3x3 column-major Q16.16 matrix per cycle and returns column lengths (or a
// unit scale while report_scale is clear) and a Q2.30 quaternion after squaring and summing
// (2 stages), a 32-stage column-length square root, a 32-stage normalizing divider, two stages
// for saturation, trace and branch selection, a 32-stage square root of the branch argument,
// one stage for the numerators, a 32-stage quaternion divider and the output register.
// The whole pipeline advances together, so it holds while a result waits on m_tready.
// Degenerate matrices give the identity quaternion with the degenerate flag in m_tuser.
`default_nettype none

module transform_to_scale_quaternion_unit
    import tsq_pkg::*;
#(
    parameter int MATRIX_FRAC_BITS = tsq_pkg::MATRIX_FRAC_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data,   // report_scale
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
    output logic      [223:0] m_tdata,
    // degenerate
    output logic      [0:0]   m_tuser
);

    localparam int EPW  = 9 * DATA_W;
    localparam int LPW  = 3 * DATA_W;
    localparam int S1PW = 2 + 1 + 6 * DATA_W + LPW;
    localparam int D1PW = 2 + 1 + DATA_W + LPW;

    logic adv;
    logic report_scale_reg;

    // Stage 1: squares.
    logic                   v1_reg;
    logic [8:0][DATA_W-1:0] e1_reg;
    logic [8:0][SQ_W-1:0]   sq1_reg;
    logic [8:0][DATA_W-1:0] in_mag;

    // Stage 2: column sums.
    logic                   v2_reg;
    logic [8:0][DATA_W-1:0] e2_reg;
    logic [2:0][SQ_W-1:0]   sum2_reg;

    logic                   sq0_valid;
    logic [2:0][DATA_W-1:0] sq0_root;
    logic [EPW-1:0]         sq0_pay;

    logic [8:0][DATA_W-1:0] d0_mag;
    logic [8:0]             d0_neg_in;
    logic [8:0][DEN_W-1:0]  d0_den;
    logic                   d0_valid;
    logic [8:0][QUO_W-1:0]  d0_q;
    logic [8:0]             d0_ovf;
    logic [8:0]             d0_neg;
    logic [LPW-1:0]         d0_pay;
    logic [2:0][DATA_W-1:0] d0_len;

    // Stage 3: normalized matrix, lane index col * 3 + row.
    logic                   v3_reg;
    logic [8:0][DATA_W-1:0] m3_reg;
    logic [LPW-1:0]         len3_reg;
    logic [8:0][DATA_W-1:0] m3_next;

    // Stage 4: branch and square-root argument.
    logic                   v4_reg;
    branch_t                br4_reg;
    logic                   deg4_reg;
    logic [32:0]            arg4_reg;
    logic [5:0][DATA_W-1:0] off4_reg;
    logic [LPW-1:0]         len4_reg;
    branch_t                br4_next;
    logic signed [34:0]     arg4_next;
    logic signed [34:0]     m00;
    logic signed [34:0]     m11;
    logic signed [34:0]     m22;
    logic signed [34:0]     trace;

    logic                   sq1_valid;
    logic [0:0][DATA_W-1:0] sq1_root;
    logic [S1PW-1:0]        sq1_pay;
    logic [0:0][SQ_W-1:0]   sq1_x;

    // Stage 5 inputs unpacked from the square-root payload.
    branch_t                br5;
    logic                   deg5;
    logic signed [32:0]     m01;
    logic signed [32:0]     m10;
    logic signed [32:0]     m02;
    logic signed [32:0]     m20;
    logic signed [32:0]     m12;
    logic signed [32:0]     m21;
    logic [LPW-1:0]         len5;
    logic [2:0][32:0]       num5;

    logic                   v5_reg;
    logic [2:0][DATA_W-1:0] mag5_reg;
    logic [2:0]             neg5_reg;
    logic [DEN_W-1:0]       s5_reg;
    logic [D1PW-1:0]        pay5_reg;

    logic                   d1_valid;
    logic [2:0][QUO_W-1:0]  d1_q;
    logic [2:0]             d1_ovf;
    logic [2:0]             d1_neg;
    logic [D1PW-1:0]        d1_pay;
    logic [2:0][DEN_W-1:0]  d1_den;

    branch_t                brf;
    logic                   degf;
    logic [DATA_W-1:0]      halff;
    logic [LPW-1:0]         lenf;
    logic [2:0][DATA_W-1:0] qf;
    logic [3:0][DATA_W-1:0] quat;
    logic [2:0][DATA_W-1:0] scale;

    logic                   out_valid_reg;
    logic [223:0]           out_data_reg;
    logic                   out_deg_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_scale_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            report_scale_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            in_mag[i] = s_tdata[32*i + 31] ? (32'd0 - s_tdata[32*i +: 32]) : s_tdata[32*i +: 32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= d0_valid;
            v4_reg <= v3_reg;
            v5_reg <= sq1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg <= s_tdata;
            for (int i = 0; i < 9; i++) begin
                sq1_reg[i] <= SQ_W'(in_mag[i]) * SQ_W'(in_mag[i]);
            end
            e2_reg <= e1_reg;
            for (int c = 0; c < 3; c++) begin
                sum2_reg[c] <= sq1_reg[3*c] + sq1_reg[3*c+1] + sq1_reg[3*c+2];
            end
        end
    end

    tsq_sqrt_pipe #(.LANES(3), .W(SQ_W), .PW(EPW)) u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v2_reg),
        .in_x      (sum2_reg),
        .in_pay    (e2_reg),
        .out_valid (sq0_valid),
        .out_root  (sq0_root),
        .out_pay   (sq0_pay)
    );

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            d0_neg_in[i] = sq0_pay[32*i + 31];
            d0_mag[i]    = d0_neg_in[i] ? (32'd0 - sq0_pay[32*i +: 32]) : sq0_pay[32*i +: 32];
            d0_den[i]    = {1'b0, sq0_root[i / 3]};
        end
    end

    tsq_div_pipe #(.LANES(9), .PW(LPW)) u_norm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq0_valid),
        .in_mag    (d0_mag),
        .in_neg    (d0_neg_in),
        .in_den    (d0_den),
        .in_pay    (sq0_root),
        .out_valid (d0_valid),
        .out_q     (d0_q),
        .out_ovf   (d0_ovf),
        .out_neg   (d0_neg),
        .out_pay   (d0_pay)
    );

    assign d0_len = d0_pay;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            // A zero-length column stays all zero.
            m3_next[i] = (d0_len[i / 3] == '0) ? '0 : sat_q30(d0_q[i], d0_ovf[i], d0_neg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_reg   <= m3_next;
            len3_reg <= d0_pay;
        end
    end

    always_comb begin
        m00   = 35'($signed(m3_reg[0]));
        m11   = 35'($signed(m3_reg[4]));
        m22   = 35'($signed(m3_reg[8]));
        trace = m00 + m11 + m22;
        if (trace > 0) begin
            br4_next  = BR_TRACE;
            arg4_next = trace + ARG_ONE;
        end else if (m00 > m11 && m00 > m22) begin
            br4_next  = BR_X;
            arg4_next = ARG_ONE + m00 - m11 - m22;
        end else if (m11 > m22) begin
            br4_next  = BR_Y;
            arg4_next = ARG_ONE + m11 - m00 - m22;
        end else begin
            br4_next  = BR_Z;
            arg4_next = ARG_ONE + m22 - m00 - m11;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            br4_reg  <= br4_next;
            deg4_reg <= (arg4_next <= 0);
            arg4_reg <= arg4_next[32:0];
            // m01, m10, m02, m20, m12, m21
            off4_reg <= {m3_reg[5], m3_reg[7], m3_reg[2], m3_reg[6], m3_reg[1], m3_reg[3]};
            len4_reg <= len3_reg;
        end
    end

    assign sq1_x[0] = deg4_reg ? '0 : {1'b0, arg4_reg, 30'd0};

    tsq_sqrt_pipe #(.LANES(1), .W(SQ_W), .PW(S1PW)) u_arg_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_x      (sq1_x),
        .in_pay    ({len4_reg, off4_reg, deg4_reg, br4_reg}),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_pay   (sq1_pay)
    );

    always_comb begin
        br5  = branch_t'(sq1_pay[1:0]);
        deg5 = sq1_pay[2];
        m01  = 33'($signed(sq1_pay[3 +: 32]));
        m10  = 33'($signed(sq1_pay[35 +: 32]));
        m02  = 33'($signed(sq1_pay[67 +: 32]));
        m20  = 33'($signed(sq1_pay[99 +: 32]));
        m12  = 33'($signed(sq1_pay[131 +: 32]));
        m21  = 33'($signed(sq1_pay[163 +: 32]));
        len5 = sq1_pay[195 +: LPW];
        // Lanes hold the three quotients in output order with the root term left out.
        case (br5)
            BR_TRACE: begin
                num5[0] = m21 - m12;
                num5[1] = m02 - m20;
                num5[2] = m10 - m01;
            end
            BR_X: begin
                num5[0] = m01 + m10;
                num5[1] = m02 + m20;
                num5[2] = m21 - m12;
            end
            BR_Y: begin
                num5[0] = m01 + m10;
                num5[1] = m12 + m21;
                num5[2] = m02 - m20;
            end
            default: begin
                num5[0] = m02 + m20;
                num5[1] = m12 + m21;
                num5[2] = m10 - m01;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                neg5_reg[i] <= num5[i][32];
                mag5_reg[i] <= num5[i][32] ? 32'(33'd0 - num5[i]) : num5[i][31:0];
            end
            s5_reg   <= {sq1_root[0], 1'b0};
            pay5_reg <= {len5, 1'b0, sq1_root[0][31:1], deg5, br5};
        end
    end

    assign d1_den = {s5_reg, s5_reg, s5_reg};

    tsq_div_pipe #(.LANES(3), .PW(D1PW)) u_quat_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v5_reg),
        .in_mag    (mag5_reg),
        .in_neg    (neg5_reg),
        .in_den    (d1_den),
        .in_pay    (pay5_reg),
        .out_valid (d1_valid),
        .out_q     (d1_q),
        .out_ovf   (d1_ovf),
        .out_neg   (d1_neg),
        .out_pay   (d1_pay)
    );

    always_comb begin
        brf   = branch_t'(d1_pay[1:0]);
        degf  = d1_pay[2];
        halff = d1_pay[3 +: 32];
        lenf  = d1_pay[35 +: LPW];
        for (int i = 0; i < 3; i++) begin
            qf[i]    = sat_q30(d1_q[i], d1_ovf[i], d1_neg[i]);
            scale[i] = report_scale_reg ? lenf[32*i +: 32] : 32'(64'd1 << MATRIX_FRAC_BITS);
        end
        if (degf) begin
            quat = {Q30_ONE, 32'd0, 32'd0, 32'd0};
        end else begin
            case (brf)
                BR_TRACE: quat = {halff, qf[2], qf[1], qf[0]};
                BR_X:     quat = {qf[2], qf[1], qf[0], halff};
                BR_Y:     quat = {qf[2], qf[1], halff, qf[0]};
                default:  quat = {qf[2], halff, qf[1], qf[0]};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= {scale, quat};
            out_deg_reg  <= degf;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_deg_reg;

`ifndef SYNTHESIS
    a_degenerate_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[127:0] == {Q30_ONE, 96'd0}))
        else $error("degenerate result is not the identity quaternion");

    a_unit_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !report_scale_reg) |->
            (m_tdata[159:128] == 32'(64'd1 << MATRIX_FRAC_BITS)))
        else $error("unit scale expected while scale reporting is off");

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== dv/transform_to_scale_quaternion_unit_test.sv =====
// Self-checking test of the transform-to-scale-quaternion unit with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none

module transform_to_scale_quaternion_unit_test;
    import tsq_pkg::*;

    localparam int PIPE_LAT = 140;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] scale_z;
        logic [31:0] scale_y;
        logic [31:0] scale_x;
        logic [31:0] quat_w;
        logic [31:0] quat_z;
        logic [31:0] quat_y;
        logic [31:0] quat_x;
    } pose_t;

    typedef struct {
        pose_t pose;
        logic  degenerate;
    } pose_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic         cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;
    logic [0:0]   m_tuser;

    logic [287:0]   matrix_queue[$];
    pose_result_t   expected_poses[$];
    logic           report_scale_model;
    int             error_count;
    longint         cycle_count;
    int             send_wait;
    int             recv_wait;
    bit             sender_hold;

    transform_to_scale_quaternion_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Signed (num * 2^30) / den, truncated toward zero and saturated to 32 bits.
    function automatic longint q30_quotient(input longint num, input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        if (den == 0) return 0;
        mag = (num < 0) ? -num : num;
        q = (mag << 30) / den;
        if (num < 0) return (q >= 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(q);
        return (q > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(q);
    endfunction

    function automatic pose_result_t predict_pose(input logic [287:0] mat);
        pose_result_t res;
        longint m[3][3];
        logic [63:0] len[3];
        longint e[3];
        logic [63:0] sum, mag, r, s;
        longint trace, arg, qx, qy, qz, qw;
        branch_t br;
        for (int c = 0; c < 3; c++) begin
            sum = 0;
            for (int row = 0; row < 3; row++) begin
                e[row] = longint'($signed(mat[(c * 3 + row) * 32 +: 32]));
                mag = (e[row] < 0) ? -e[row] : e[row];
                sum += mag * mag;
            end
            len[c] = int_sqrt(sum);
            for (int row = 0; row < 3; row++)
                m[row][c] = (len[c] != 0) ? q30_quotient(e[row], len[c]) : 0;
        end
        trace = m[0][0] + m[1][1] + m[2][2];
        if (trace > 0) begin
            br = BR_TRACE;
            arg = trace + (64'd1 << 30);
        end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
            br = BR_X;
            arg = (64'd1 << 30) + m[0][0] - m[1][1] - m[2][2];
        end else if (m[1][1] > m[2][2]) begin
            br = BR_Y;
            arg = (64'd1 << 30) + m[1][1] - m[0][0] - m[2][2];
        end else begin
            br = BR_Z;
            arg = (64'd1 << 30) + m[2][2] - m[0][0] - m[1][1];
        end
        res.degenerate = (arg <= 0);
        if (arg <= 0) begin
            qx = 0; qy = 0; qz = 0; qw = 64'd1 << 30;
        end else begin
            r = int_sqrt(64'(arg) << 30);
            s = r << 1;
            case (br)
                BR_TRACE: begin
                    qx = q30_quotient(m[2][1] - m[1][2], s);
                    qy = q30_quotient(m[0][2] - m[2][0], s);
                    qz = q30_quotient(m[1][0] - m[0][1], s);
                    qw = r >> 1;
                end
                BR_X: begin
                    qx = r >> 1;
                    qy = q30_quotient(m[0][1] + m[1][0], s);
                    qz = q30_quotient(m[0][2] + m[2][0], s);
                    qw = q30_quotient(m[2][1] - m[1][2], s);
                end
                BR_Y: begin
                    qx = q30_quotient(m[0][1] + m[1][0], s);
                    qy = r >> 1;
                    qz = q30_quotient(m[1][2] + m[2][1], s);
                    qw = q30_quotient(m[0][2] - m[2][0], s);
                end
                default: begin
                    qx = q30_quotient(m[0][2] + m[2][0], s);
                    qy = q30_quotient(m[1][2] + m[2][1], s);
                    qz = r >> 1;
                    qw = q30_quotient(m[1][0] - m[0][1], s);
                end
            endcase
        end
        res.pose.quat_x = qx[31:0];
        res.pose.quat_y = qy[31:0];
        res.pose.quat_z = qz[31:0];
        res.pose.quat_w = qw[31:0];
        res.pose.scale_x = report_scale_model ? len[0][31:0] : 32'(1) << MATRIX_FRAC_BITS;
        res.pose.scale_y = report_scale_model ? len[1][31:0] : 32'(1) << MATRIX_FRAC_BITS;
        res.pose.scale_z = report_scale_model ? len[2][31:0] : 32'(1) << MATRIX_FRAC_BITS;
        return res;
    endfunction

    function automatic logic [31:0] random_entry();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: v = 0;
            default: v = 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
        return v;
    endfunction

    // Rotation-like: signed permutation scaled per column, small noise; else random.
    function automatic logic [287:0] random_matrix();
        logic [287:0] mat;
        int perm[3];
        int tmp, j, sc;
        logic [31:0] ent;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
        end
        if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < 9; k++) mat[k * 32 +: 32] = random_entry();
        end else begin
            for (int c = 0; c < 3; c++) begin
                sc = $urandom_range(1, 2000000);
                for (int row = 0; row < 3; row++) begin
                    ent = 32'($signed($urandom_range(0, 2000)) - 1000);
                    if (row == perm[c]) ent = $urandom_range(0, 1) ? 32'(sc) : -32'(sc);
                    mat[(c * 3 + row) * 32 +: 32] = ent;
                end
            end
        end
        return mat;
    endfunction

    function automatic logic [287:0] diag_matrix(input logic [31:0] a, input logic [31:0] b,
                                                 input logic [31:0] c);
        logic [287:0] mat;
        mat = '0;
        mat[0 +: 32] = a;
        mat[4 * 32 +: 32] = b;
        mat[8 * 32 +: 32] = c;
        return mat;
    endfunction

    task automatic wait_drained();
        while (matrix_queue.size() != 0 || expected_poses.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    task automatic write_report_scale(input logic value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        report_scale_model = value;
    endtask

    // Predictions are made when the matrix is queued; the register only changes while idle.
    task automatic queue_matrix(input logic [287:0] mat);
        matrix_queue.insert(matrix_queue.size(), mat);
        expected_poses.insert(expected_poses.size(), predict_pose(mat));
    endtask

    task automatic queue_directed();
        logic [287:0] mat;
        queue_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        queue_matrix(diag_matrix(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        queue_matrix(diag_matrix(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000));
        queue_matrix(diag_matrix(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000));
        queue_matrix(diag_matrix(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        queue_matrix('0);
        queue_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        queue_matrix({9{32'h8000_0000}});
        queue_matrix({9{32'h7FFF_FFFF}});
        queue_matrix({9{32'hFFFF_FFFF}});
        queue_matrix({9{32'h0000_0001}});
        queue_matrix(diag_matrix(32'h0003_0000, 32'h0000_0000, 32'h0000_8000));
        // A matrix with skewed, non-orthogonal columns, then a quarter turn about z.
        mat = '0;
        mat[0 +: 32] = 32'h0001_0000; mat[32 +: 32] = 32'h0000_0010;
        mat[96 +: 32] = 32'h0001_0000; mat[128 +: 32] = 32'h0000_0020;
        mat[224 +: 32] = 32'hFFFF_0000; mat[256 +: 32] = 32'h0000_0001;
        queue_matrix(mat);
        mat = '0;
        mat[32 +: 32] = 32'h0001_0000; mat[96 +: 32] = 32'hFFFF_0000;
        mat[256 +: 32] = 32'h0001_0000;
        queue_matrix(mat);
        for (int k = 0; k < 4; k++) queue_matrix(random_matrix());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        report_scale_model = 1'b0;
        error_count = 0;
        sender_hold = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        queue_directed();
        wait_drained();
        write_report_scale(1'b1);
        queue_directed();
        for (int k = 0; k < 200; k++) queue_matrix(random_matrix());
        // Midway through the stream, hold the sender off until the pipeline has emptied.
        while (matrix_queue.size() > 100) @(posedge aclk);
        sender_hold = 1'b1;
        while (expected_poses.size() > matrix_queue.size()) @(posedge aclk);
        sender_hold = 1'b0;
        wait_drained();
        write_report_scale(1'b0);
        for (int k = 0; k < 150; k++) queue_matrix(random_matrix());
        wait_drained();
        write_report_scale(1'b1);
        for (int k = 0; k < 160; k++) queue_matrix(random_matrix());
        wait_drained();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Sender: presents queued matrices with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_wait <= 0;
        end else if (s_tvalid && !s_tready) begin
            // Transaction still pending.
        end else if (send_wait != 0) begin
            s_tvalid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (matrix_queue.size() != 0 && !sender_hold) begin
            s_tvalid <= 1'b1;
            s_tdata <= matrix_queue.pop_front();
            send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure and comparison against the oldest prediction.
    always @(posedge aclk) begin
        pose_result_t want;
        pose_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait <= 0;
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_poses.size() == 0) begin
                    $display("%0t unexpected result %h", $time, m_tdata);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_poses.pop_front();
                    if (got !== want.pose || m_tuser[0] !== want.degenerate) begin
                        $display("%0t mismatch expected %h deg %b actual %h deg %b", $time,
                                 want.pose, want.degenerate, got, m_tuser[0]);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (recv_wait != 0) begin
                m_tready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            end
        end
    end

endmodule

`default_nettype wire
